@@ hdl/ggs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggs_pkg
// Shared types and constants of the grid gradient stencil block.
// ----------------------------------------------------------------------------
package ggs_pkg;

    // Item field widths
    localparam int ROW_W       = 8;
    localparam int COL_W       = 8;
    localparam int IN_SAMPLE_W = 32;
    localparam int GRAD_W      = 48;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int DIM_CFG_W  = 9;
    localparam int INV_W      = 32;

    localparam logic [1:0] REG_GRID_COLS  = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS  = 2'd1;
    localparam logic [1:0] REG_INV_TWO_DX = 2'd2;
    localparam logic [1:0] REG_INV_TWO_DZ = 2'd3;

    localparam logic [DIM_CFG_W-1:0] GRID_DIM_RST = 9'd256;
    localparam logic [INV_W-1:0]     INV_RST      = 32'd32768;
    localparam int                   DIM_MIN      = 3;

    // Read slots of one query: centre, two x neighbours, two z neighbours
    localparam logic [2:0] RD_CENTRE = 3'd0;
    localparam logic [2:0] RD_XA     = 3'd1;
    localparam logic [2:0] RD_XB     = 3'd2;
    localparam logic [2:0] RD_ZA     = 3'd3;
    localparam logic [2:0] RD_ZB     = 3'd4;

    // Scaling: rounding and saturation
    localparam int              PROD_W     = 64;
    localparam int              PRND_W     = 49;
    localparam int              SUM_W      = 50;
    localparam logic [PROD_W:0] ROUND_HALF = 65'h8000;
    localparam logic [SUM_W-1:0] POS_LIM   = 50'h0_7FFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] NEG_LIM   = 50'h0_8000_0000_0000;

    // Stencil weight applied to one sample
    typedef enum logic [2:0] {
        C_ZERO = 3'd0,
        C_P1   = 3'd1,
        C_M1   = 3'd2,
        C_P3   = 3'd3,
        C_M3   = 3'd4,
        C_P4   = 3'd5,
        C_M4   = 3'd6
    } t_coef;

    // Sequencer states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_WAIT = 8'b0000_0100,
        S_ABS  = 8'b0000_1000,
        S_MLO  = 8'b0001_0000,
        S_MHI  = 8'b0010_0000,
        S_RND  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

@@ hdl/ggs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggs_if
// Item channels of the grid gradient stencil block: request in, result out.
// ----------------------------------------------------------------------------

// Request channel: sample writes and gradient queries
interface ggs_in_if import ggs_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [ROW_W-1:0]               row;
    logic [COL_W-1:0]               col;
    logic signed [IN_SAMPLE_W-1:0]  sample;

    modport source (output valid, output opcode, output row, output col,
                    output sample, input ready);
    modport sink   (input valid, input opcode, input row, input col,
                    input sample, output ready);
endinterface

// Result channel: one item per query
interface ggs_out_if import ggs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_z;
    logic                      out_of_range;

    modport source (output valid, output grad_x, output grad_z,
                    output out_of_range, input ready);
    modport sink   (input valid, input grad_x, input grad_z,
                    input out_of_range, output ready);
endinterface

@@ hdl/grid_gradient_stencil_2d_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_gradient_stencil_2d_top
// 2D sample grid in one single-port RAM with point gradient queries.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : request items. opcode write stores sample at (row, col), no
//           result. opcode query returns grad_x / grad_z at (row, col).
//   o_out : result items, one per query, held in an output register.
//   APB   : grid_cols @0x0, grid_rows @0x4, inv_two_dx @0x8, inv_two_dz @0xC.
// Timing
//   A write is stored at acceptance; back-to-back writes run at one item per
//   cycle while the sequencer is idle. An in-range query makes five reads of
//   the single-port grid RAM (one per cycle, registered read), then two
//   passes (x, z) through the ABS, MLO, MHI and RND states (low 32x32 product,
//   then high part), then the output load. i_in.ready returns with the result,
//   so a query holds the block until its result loads; out-of-range skips reads.
// Reset and stall
//   Reset loads the register defaults and empties the sequencer and output
//   register; the RAM is not cleared, so only written entries may be read.
//   While the receiver stalls the result is held and new items are still
//   taken; a second result waits in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module grid_gradient_stencil_2d_top import ggs_pkg::*; #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    ggs_in_if.sink                 i_in,
    ggs_out_if.source              o_out
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int AXW     = AW + 9;
    localparam int DC_W    = ($clog2(MAX_COLS + 1) > DIM_CFG_W) ?
                             $clog2(MAX_COLS + 1) : DIM_CFG_W;
    localparam int DR_W    = ($clog2(MAX_ROWS + 1) > DIM_CFG_W) ?
                             $clog2(MAX_ROWS + 1) : DIM_CFG_W;
    localparam int SXW     = (SAMPLE_BITS > IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
    localparam int D_W     = SAMPLE_BITS + 4;
    localparam int MAG_W   = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;
    localparam int MXW     = (D_W > MAG_W) ? D_W : MAG_W;
    localparam int QW      = MAG_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] f_addr(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col);
        logic [AXW-1:0] full;
        full = AXW'(row) * AXW'(MAX_COLS) + AXW'(col);
        return full[AW-1:0];
    endfunction

    function automatic logic signed [D_W-1:0] f_term(input t_coef k,
                                                     input logic signed [D_W-1:0] s);
        logic signed [D_W-1:0] s3;
        logic signed [D_W-1:0] t;
        s3 = s + (s <<< 1);
        case (k)
            C_P1:    t = s;
            C_M1:    t = -s;
            C_P3:    t = s3;
            C_M3:    t = -s3;
            C_P4:    t = s <<< 2;
            C_M4:    t = -(s <<< 2);
            default: t = '0;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_CFG_W-1:0] r_grid_cols;
    logic [DIM_CFG_W-1:0] r_grid_rows;
    logic [INV_W-1:0]     r_inv_dx;
    logic [INV_W-1:0]     r_inv_dz;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_DIM_RST;
            r_grid_rows <= GRID_DIM_RST;
            r_inv_dx    <= INV_RST;
            r_inv_dz    <= INV_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_GRID_COLS:  r_grid_cols <= pwdata[DIM_CFG_W-1:0];
                REG_GRID_ROWS:  r_grid_rows <= pwdata[DIM_CFG_W-1:0];
                REG_INV_TWO_DX: r_inv_dx    <= pwdata;
                REG_INV_TWO_DZ: r_inv_dz    <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_COLS:  prdata = APB_DATA_W'(r_grid_cols);
            REG_GRID_ROWS:  prdata = APB_DATA_W'(r_grid_rows);
            REG_INV_TWO_DX: prdata = r_inv_dx;
            REG_INV_TWO_DZ: prdata = r_inv_dz;
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Grid size in use, clamped to 3 .. MAX
    // ------------------------------------------------------------------
    logic [DC_W-1:0] ncols;
    logic [DR_W-1:0] nrows;
    logic [DC_W-1:0] in_col_d;
    logic [DR_W-1:0] in_row_d;

    always_comb begin
        if (r_grid_cols < DIM_CFG_W'(DIM_MIN))
            ncols = DC_W'(DIM_MIN);
        else if (DC_W'(r_grid_cols) > DC_W'(MAX_COLS))
            ncols = DC_W'(MAX_COLS);
        else
            ncols = DC_W'(r_grid_cols);
        if (r_grid_rows < DIM_CFG_W'(DIM_MIN))
            nrows = DR_W'(DIM_MIN);
        else if (DR_W'(r_grid_rows) > DR_W'(MAX_ROWS))
            nrows = DR_W'(MAX_ROWS);
        else
            nrows = DR_W'(r_grid_rows);
    end

    assign in_col_d = DC_W'(i_in.col);
    assign in_row_d = DR_W'(i_in.row);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   is_query;
    logic   q_oor;
    logic   out_load;
    logic [2:0] r_rd_idx;
    logic   r_dir;
    logic   r_out_valid;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;
    assign is_query   = (i_in.opcode == OP_QUERY);
    assign q_oor      = (in_col_d >= ncols) || (in_row_d >= nrows);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query)
                    n_state = q_oor ? S_OUT : S_READ;
            end
            S_READ: begin
                if (r_rd_idx == RD_ZB)
                    n_state = S_WAIT;
            end
            S_WAIT: n_state = S_ABS;
            S_ABS:  n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_RND;
            S_RND:  n_state = r_dir ? S_OUT : S_ABS;
            S_OUT: begin
                if (out_load)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= RD_CENTRE;
            r_dir    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE)
                r_rd_idx <= RD_CENTRE;
            else if (r_state == S_READ)
                r_rd_idx <= r_rd_idx + 3'd1;
            if (r_state == S_WAIT)
                r_dir <= 1'b0;
            else if (r_state == S_RND)
                r_dir <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stencil selection at query acceptance
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_row, r_za, r_zb;
    logic [COL_W-1:0] r_col, r_xa, r_xb;
    t_coef            r_kx0, r_kxa, r_kxb, r_kz0, r_kza, r_kzb;

    always_ff @(posedge i_clk) begin
        if (in_acc && is_query) begin
            r_row <= i_in.row;
            r_col <= i_in.col;
            // x direction: first column, last column, interior
            if (i_in.col == '0) begin
                r_xa <= i_in.col + COL_W'(1);  r_kxa <= C_P4;
                r_xb <= i_in.col + COL_W'(2);  r_kxb <= C_M1;
                r_kx0 <= C_M3;
            end else if (in_col_d == ncols - DC_W'(1)) begin
                r_xa <= i_in.col - COL_W'(1);  r_kxa <= C_M4;
                r_xb <= i_in.col - COL_W'(2);  r_kxb <= C_P1;
                r_kx0 <= C_P3;
            end else begin
                r_xa <= i_in.col + COL_W'(1);  r_kxa <= C_P1;
                r_xb <= i_in.col - COL_W'(1);  r_kxb <= C_M1;
                r_kx0 <= C_ZERO;
            end
            // z direction
            if (i_in.row == '0) begin
                r_za <= i_in.row + ROW_W'(1);  r_kza <= C_P4;
                r_zb <= i_in.row + ROW_W'(2);  r_kzb <= C_M1;
                r_kz0 <= C_M3;
            end else if (in_row_d == nrows - DR_W'(1)) begin
                r_za <= i_in.row - ROW_W'(1);  r_kza <= C_M4;
                r_zb <= i_in.row - ROW_W'(2);  r_kzb <= C_P1;
                r_kz0 <= C_P3;
            end else begin
                r_za <= i_in.row + ROW_W'(1);  r_kza <= C_P1;
                r_zb <= i_in.row - ROW_W'(1);  r_kzb <= C_M1;
                r_kz0 <= C_ZERO;
            end
        end
    end

    // ------------------------------------------------------------------
    // Grid RAM: single port, registered read
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_grid_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic [SXW-1:0]         wr_ext;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [ROW_W-1:0]       rd_row;
    logic [COL_W-1:0]       rd_col;

    assign wr_ext = SXW'(unsigned'(i_in.sample));
    assign mem_we = in_acc && (i_in.opcode == OP_WRITE)
                    && (in_row_d < DR_W'(MAX_ROWS)) && (in_col_d < DC_W'(MAX_COLS));

    // Read slot to grid position
    always_comb begin
        rd_row = r_row;
        rd_col = r_col;
        case (r_rd_idx)
            RD_XA:   rd_col = r_xa;
            RD_XB:   rd_col = r_xb;
            RD_ZA:   rd_row = r_za;
            RD_ZB:   rd_row = r_zb;
            default: ;
        endcase
    end

    assign mem_addr = (r_state == S_IDLE) ? f_addr(i_in.row, i_in.col)
                                          : f_addr(rd_row, rd_col);

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_grid_mem[mem_addr] <= wr_ext[SAMPLE_BITS-1:0];
        else
            r_rdata <= r_grid_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Accumulate stencil terms as read data returns
    // ------------------------------------------------------------------
    logic                  r_fetch_valid;
    logic [2:0]            r_fetch_idx;
    logic signed [D_W-1:0] s_fetch;
    logic signed [D_W-1:0] r_acc_x, r_acc_z;

    assign s_fetch = {{(D_W - SAMPLE_BITS){r_rdata[SAMPLE_BITS-1]}}, r_rdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_fetch_valid <= 1'b0;
        else
            r_fetch_valid <= (r_state == S_READ);
    end

    always_ff @(posedge i_clk) begin
        r_fetch_idx <= r_rd_idx;
        if (r_fetch_valid) begin
            case (r_fetch_idx)
                RD_CENTRE: begin
                    r_acc_x <= f_term(r_kx0, s_fetch);
                    r_acc_z <= f_term(r_kz0, s_fetch);
                end
                RD_XA:   r_acc_x <= r_acc_x + f_term(r_kxa, s_fetch);
                RD_XB:   r_acc_x <= r_acc_x + f_term(r_kxb, s_fetch);
                RD_ZA:   r_acc_z <= r_acc_z + f_term(r_kza, s_fetch);
                RD_ZB:   r_acc_z <= r_acc_z + f_term(r_kzb, s_fetch);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scaling: |d| * inv as a low 32-bit part and a high part, round, saturate, re-sign
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] acc_sel;
    logic [D_W-1:0]        abs_d;
    logic [MXW-1:0]        abs_x;
    logic [MAG_W-1:0]      r_mag;
    logic [INV_W-1:0]      r_inv;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_plo;
    logic [QW-1:0]         r_phi;
    logic [PROD_W:0]       plo_rnd;
    logic [PRND_W-1:0]     r_prnd;
    logic                  sat_hi;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      lim;
    logic [SUM_W-1:0]      mag_c;
    logic [GRAD_W-1:0]     n_grad;
    logic [GRAD_W-1:0]     r_gx, r_gz;
    logic                  r_oor;

    assign acc_sel = r_dir ? r_acc_z : r_acc_x;
    assign abs_d   = acc_sel[D_W-1] ? unsigned'(-acc_sel) : unsigned'(acc_sel);
    assign abs_x   = MXW'(abs_d);
    assign plo_rnd = {1'b0, r_plo} + ROUND_HALF;

    assign sat_hi = |r_phi[QW-1:31];
    assign sum    = SUM_W'(r_prnd) + SUM_W'({r_phi[30:0], 16'b0});
    assign lim    = r_neg ? NEG_LIM : POS_LIM;
    assign mag_c  = (sat_hi || (sum > lim)) ? lim : sum;
    assign n_grad = r_neg ? (~mag_c[GRAD_W-1:0] + GRAD_W'(1)) : mag_c[GRAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_ABS) begin
            r_mag <= abs_x[MAG_W-1:0];
            r_neg <= acc_sel[D_W-1];
            r_inv <= r_dir ? r_inv_dz : r_inv_dx;
        end
        if (r_state == S_MLO)
            r_plo <= r_mag[31:0] * r_inv;
        if (r_state == S_MHI) begin
            r_phi  <= r_mag[MAG_W-1:32] * r_inv;
            r_prnd <= plo_rnd[PROD_W:16];
        end
        if (r_state == S_RND) begin
            if (r_dir)
                r_gz <= n_grad;
            else
                r_gx <= n_grad;
        end
        // Query result flag; outside the grid the gradients are zero
        if (in_acc && is_query) begin
            r_oor <= q_oor;
            if (q_oor) begin
                r_gx <= '0;
                r_gz <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [GRAD_W-1:0] r_out_gx, r_out_gz;
    logic              r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_load)
            r_out_valid <= 1'b1;
        else if (o_out.ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_gx  <= r_gx;
            r_out_gz  <= r_gz;
            r_out_oor <= r_oor;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.grad_x       = signed'(r_out_gx);
    assign o_out.grad_z       = signed'(r_out_gz);
    assign o_out.out_of_range = r_out_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_only_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE))
        else $error("grid write outside idle");

    a_oor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |-> (o_out.grad_x == '0 && o_out.grad_z == '0))
        else $error("out-of-range result with non-zero gradient");

    a_read_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_query && !q_oor) |=> (r_state == S_READ && r_rd_idx == RD_CENTRE))
        else $error("query did not start at the centre read");

    a_last_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_rd_idx == RD_ZB) |=> (r_state == S_WAIT && r_fetch_valid))
        else $error("read sequence overran");

endmodule
